// ===== rtl/plti_pkg.sv =====
`timescale 1ns / 1ps

package plti_pkg;

  localparam int DEPTH     = 256;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BELOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE = 2'd2;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_POS     = 3'd1,
    ST_NOT_INCR    = 3'd2,
    ST_FULL        = 3'd3,
    ST_TOO_SMALL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RGN_INTERIOR = 2'd0,
    RGN_BELOW    = 2'd1,
    RGN_ABOVE    = 2'd2
  } region_t;

  typedef struct packed {
    req_t                    req_type;
    logic signed [KEY_W-1:0] point_key;
    logic signed [VAL_W-1:0] point_value;
  } in_word_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] rate_value;
    region_t                 region;
  } out_word_t;

endpackage

// ===== rtl/piecewise_linear_table_interp.sv =====
`timescale 1ns / 1ps

// Channel  Ports                          Handshake
// input    in_word                        accepted when start is high and busy is low
// result   out_word                       out_valid high for one cycle, no stall
// config   cfg_we, cfg_index, cfg_wdata   written when cfg_we is high
//
// Clear, append, unused, short-table and edge queries give their result in the
// cycle after acceptance and leave busy low. An interior query keeps busy high
// through a binary search of up to log2 of the depth probes (S_SRCH_RD, the
// registered table read, S_SRCH_CMP), S_DIFF, S_MUL and the 32-step serial divider.
// Reset is synchronous and active low; the table has no clearing pass.
module piecewise_linear_table_interp import plti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_word,
  output logic                 out_valid,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH_RD  = 8'b0000_0010,
    S_SRCH_CMP = 8'b0000_0100,
    S_DIFF     = 8'b0000_1000,
    S_MUL      = 8'b0001_0000,
    S_DIV_GO   = 8'b0010_0000,
    S_DIV_WAIT = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [VAL_W-1:0] floor_r, floor_nxt;
  logic                    below_r, below_nxt;
  logic                    above_r, above_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  logic signed [KEY_W-1:0] first_key_r, first_key_nxt;
  logic signed [VAL_W-1:0] first_val_r, first_val_nxt;
  logic signed [KEY_W-1:0] last_key_r, last_key_nxt;
  logic signed [VAL_W-1:0] last_val_r, last_val_nxt;

  logic signed [KEY_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic signed [KEY_W-1:0] klo_r, klo_nxt, khi_r, khi_nxt;
  logic signed [VAL_W-1:0] vlo_r, vlo_nxt, vhi_r, vhi_nxt;
  logic [DIV_W-1:0]        a_r, a_nxt, b_r, b_nxt, dk_r, dk_nxt;
  logic                    neg_r, neg_nxt;
  logic [2*DIV_W-1:0]      prod_r, prod_nxt;

  logic                    accept;
  logic signed [KEY_W-1:0] key_clamped;
  logic signed [VAL_W-1:0] val_floored;
  logic [CNT_W-1:0]        count_m1;
  logic [ADDR_W:0]         mid_sum;
  logic [ADDR_W-1:0]       mid;
  logic [ADDR_W-1:0]       span;
  logic signed [VAL_W:0]   dv;
  logic signed [DIV_W:0]   q_signed;
  logic signed [VAL_W+1:0] r_sum;

  logic                    st_wr_en;
  logic signed [KEY_W-1:0] rd_key;
  logic signed [VAL_W-1:0] rd_val;
  logic                    div_start;
  logic                    div_done;
  logic [DIV_W-1:0]        quotient;

  assign accept      = start && !busy;
  assign key_clamped = in_word.point_key[KEY_W-1] ? '0 : in_word.point_key;
  assign val_floored = (in_word.point_value < floor_r) ? floor_r : in_word.point_value;
  assign count_m1    = count_r - CNT_W'(1);
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid         = mid_sum[ADDR_W:1];
  assign span        = hi_r - lo_r;
  assign div_start   = (state_r == S_DIV_GO);

  always_comb begin
    floor_nxt     = floor_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOR: floor_nxt = cfg_wdata[VAL_W-1:0];
        CFG_BELOW: below_nxt = cfg_wdata[0];
        CFG_ABOVE: above_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    first_key_nxt = first_key_r;
    first_val_nxt = first_val_r;
    last_key_nxt  = last_key_r;
    last_val_nxt  = last_val_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    klo_nxt       = klo_r;
    khi_nxt       = khi_r;
    vlo_nxt       = vlo_r;
    vhi_nxt       = vhi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    dk_nxt        = dk_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    st_wr_en      = 1'b0;
    dv            = {vhi_r[VAL_W-1], vhi_r} - {vlo_r[VAL_W-1], vlo_r};
    q_signed      = neg_r ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    r_sum         = {{2{vlo_r[VAL_W-1]}}, vlo_r} + {q_signed[DIV_W], q_signed};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt         = 1'b1;
          out_word_nxt.status   = ST_OK;
          out_word_nxt.rate_value = '0;
          out_word_nxt.region   = RGN_INTERIOR;
          unique case (in_word.req_type)
            REQ_CLEAR: count_nxt = '0;
            REQ_APPEND: begin
              if (in_word.point_key <= 0) begin
                out_word_nxt.status = ST_NOT_POS;
              end else if (count_r != '0 && in_word.point_key <= last_key_r) begin
                out_word_nxt.status = ST_NOT_INCR;
              end else if (count_r == CNT_W'(DEPTH)) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                st_wr_en     = 1'b1;
                count_nxt    = count_r + CNT_W'(1);
                last_key_nxt = in_word.point_key;
                last_val_nxt = val_floored;
                if (count_r == '0) begin
                  first_key_nxt = in_word.point_key;
                  first_val_nxt = val_floored;
                end
              end
            end
            REQ_QUERY: begin
              if (count_r < CNT_W'(2)) begin
                out_word_nxt.status = ST_TOO_SMALL;
              end else if (key_clamped <= first_key_r) begin
                out_word_nxt.region     = RGN_BELOW;
                out_word_nxt.rate_value = below_r ? '0 : first_val_r;
              end else if (key_clamped >= last_key_r) begin
                out_word_nxt.region     = RGN_ABOVE;
                out_word_nxt.rate_value = above_r ? '0 : last_val_r;
              end else begin
                // Interior: the answer comes later, after the search.
                out_valid_nxt = 1'b0;
                k_nxt         = key_clamped;
                lo_nxt        = '0;
                hi_nxt        = count_m1[ADDR_W-1:0];
                klo_nxt       = first_key_r;
                vlo_nxt       = first_val_r;
                khi_nxt       = last_key_r;
                vhi_nxt       = last_val_r;
                state_nxt     = S_SRCH_RD;
              end
            end
            REQ_UNUSED: ;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (span > ADDR_W'(1)) begin
          mid_nxt   = mid;
          state_nxt = S_SRCH_CMP;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_SRCH_CMP: begin
        // The bracketing keys and values ride along, so no re-read is needed.
        if (rd_key <= k_r) begin
          lo_nxt  = mid_r;
          klo_nxt = rd_key;
          vlo_nxt = rd_val;
        end else begin
          hi_nxt  = mid_r;
          khi_nxt = rd_key;
          vhi_nxt = rd_val;
        end
        state_nxt = S_SRCH_RD;
      end
      S_DIFF: begin
        a_nxt     = DIV_W'(k_r - klo_r);
        dk_nxt    = DIV_W'(khi_r - klo_r);
        neg_nxt   = dv[VAL_W];
        b_nxt     = dv[VAL_W] ? DIV_W'(-dv) : DIV_W'(dv);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = a_r * b_r;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_valid_nxt           = 1'b1;
        out_word_nxt.status     = ST_OK;
        out_word_nxt.region     = RGN_INTERIOR;
        out_word_nxt.rate_value = (r_sum < $signed({{2{floor_r[VAL_W-1]}}, floor_r})) ?
                                  floor_r : r_sum[VAL_W-1:0];
        state_nxt               = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      floor_r     <= '0;
      below_r     <= 1'b0;
      above_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      floor_r     <= floor_nxt;
      below_r     <= below_nxt;
      above_r     <= above_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    first_key_r <= first_key_nxt;
    first_val_r <= first_val_nxt;
    last_key_r  <= last_key_nxt;
    last_val_r  <= last_val_nxt;
    k_r         <= k_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    klo_r       <= klo_nxt;
    khi_r       <= khi_nxt;
    vlo_r       <= vlo_nxt;
    vhi_r       <= vhi_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    dk_r        <= dk_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
  end

  plti_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_key  (in_word.point_key),
    .wr_val  (val_floored),
    .rd_addr (mid),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  plti_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .dividend  (prod_r),
    .divisor   (dk_r),
    .div_done  (div_done),
    .quotient  (quotient)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/plti_store.sv =====
`timescale 1ns / 1ps

module plti_store import plti_pkg::*; (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic signed [KEY_W-1:0] wr_key,
  input  logic signed [VAL_W-1:0] wr_val,
  input  logic [ADDR_W-1:0]       rd_addr,
  output logic signed [KEY_W-1:0] rd_key,
  output logic signed [VAL_W-1:0] rd_val
);

  logic signed [KEY_W-1:0] key_mem [DEPTH];
  logic signed [VAL_W-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

endmodule

// ===== rtl/plti_divider.sv =====
`timescale 1ns / 1ps

module plti_divider import plti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 div_start,
  input  logic [2*DIV_W-1:0]   dividend,
  input  logic [DIV_W-1:0]     divisor,
  output logic                 div_done,
  output logic [DIV_W-1:0]     quotient
);

  // The caller guarantees the quotient fits DIV_W bits, so the upper half of
  // the dividend is already below the divisor and only DIV_W steps remain.
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W+1:0]     trial;

  always_comb begin
    trial    = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, divisor};
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (div_start) begin
      rem_nxt = dividend[2*DIV_W-1:DIV_W];
      quo_nxt = dividend[DIV_W-1:0];
      cnt_nxt = DIV_CNT_W'(DIV_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[DIV_W+1]) begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign div_done = done_r;
  assign quotient = quo_r;

endmodule
